### rtl/core/mra_pkg.sv
// package: types, codes and fixed constants of the region allocator
package mra_pkg;

  localparam int MAX_REGIONS_DEF = 16;
  localparam logic [31:0] TOP_ADDRESS = 32'h8000_0000;
  localparam int PAGE_BITS = 12;
  localparam int PAGE_BYTES = 1 << PAGE_BITS;
  localparam int FILE_SLOTS = 16;
  localparam int FILE_BITS = 4;

  localparam logic CMD_MAP = 1'b0;
  localparam logic CMD_UNMAP = 1'b1;

  localparam logic [1:0] KIND_MAP = 2'd0;
  localparam logic [1:0] KIND_FREED = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic              command;
    logic [31:0]       address;
    logic signed [31:0] length;
    logic [7:0]        protection;
    logic [7:0]        map_flags;
    logic [30:0]       file_offset;
    logic signed [7:0] file_index;
    logic              file_open;
  } request_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic        last;
  } response_t;

  typedef struct packed {
    logic [31:0]          first_byte;
    logic [31:0]          last_byte;
    logic [7:0]           protection;
    logic [7:0]           flags;
    logic [31:0]          offset;
    logic [FILE_BITS-1:0] file;
  } region_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MAP_WALK,
    ST_MAP_PLACE,
    ST_MAP_FAIL,
    ST_UNMAP_WALK,
    ST_UNMAP_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_TRIM_FRONT,
    OP_TRIM_BACK,
    OP_SPLIT
  } table_op_t;

endpackage

### rtl/core/mmap_region_allocator.sv
// top level: first-fit top-down region allocator with map and unmap requests
//
// One request is taken at a time; request_ready is high only while the block is idle.
// A map walks the table entries until a gap is found (at most the region count); an
// unmap visits the entries one after another, and each visited entry that overlaps the
// range yields one freed-range beat. A map rejected on its arguments and an unmap with
// an empty range answer without a walk. Any result waits while response_ready holds
// it off. The table has a single read port, one entry per cycle; the unmap walk stalls
// on an overlapping entry while the result slot is not free. The configuration write
// (process_top) is always ready and takes effect on the next cycle.
module mmap_region_allocator
  import mra_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      request_valid,
  output logic      request_ready,
  input  request_t  request,
  output logic      response_valid,
  input  logic      response_ready,
  output response_t response,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);
  localparam logic [32:0] PAGE_MASK = 33'(PAGE_BYTES - 1);

  state_t    state, state_next;
  table_op_t op;

  region_t       tbl [MAX_REGIONS];
  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [CW-1:0] n;
  logic [CW-1:0] pos;
  logic [31:0]   hi;
  logic [32:0]   len_r;
  logic          len_ok;
  logic [32:0]   e_r;
  logic          err;
  logic [31:0]   process_top;
  request_t      req;

  logic          out_free;
  logic          emit;
  response_t     rsp_d;
  logic [1:0]    i_step;
  logic          set_err;

  logic [IW-1:0] idx;
  logic [IW-1:0] idx_up;
  region_t       cur;
  logic          i_valid;
  logic          walk;
  logic [33:0]   gap;
  logic [33:0]   tail_gap;
  logic          fit;
  logic          tail_fit;
  logic          reject;
  logic [32:0]   s33, t33, a33;
  logic          overlap, front, back, full;
  logic [32:0]   len_round;
  logic          len_pos;

  assign cfg_ready = 1'b1;
  assign request_ready = (state == ST_IDLE);
  assign out_free = !response_valid || response_ready;

  // page rounding toward +infinity, only the positive case matters
  assign len_pos = !request.length[31] && (request.length != 32'sd0);
  assign len_round = (33'(unsigned'(request.length)) + PAGE_MASK) & ~PAGE_MASK;

  assign idx = i[IW-1:0];
  assign idx_up = IW'(i + CW'(1));
  assign cur = tbl[idx];
  assign i_valid = (i < count);
  assign walk = i_valid && (n < MAX_CNT);

  assign gap = {2'b00, hi} - {2'b00, cur.last_byte} - 34'd1;
  assign fit = !gap[33] && (gap[32:0] >= len_r);
  assign tail_gap = {2'b00, hi} - {2'b00, process_top};
  assign tail_fit = !tail_gap[33] && (tail_gap[32:0] >= len_r);

  assign reject = (req.address >= TOP_ADDRESS) || req.file_index[7]
               || (req.file_index >= 8'(FILE_SLOTS)) || !req.file_open
               || !len_ok || (len_r[32:31] != 2'b00) || (count >= MAX_CNT);

  assign s33 = {1'b0, cur.first_byte};
  assign t33 = {1'b0, cur.last_byte};
  assign a33 = {1'b0, req.address};
  assign overlap = (s33 < e_r) && (t33 >= a33);
  assign front = (a33 <= s33);
  assign back = (e_r > t33);
  assign full = (count >= MAX_CNT);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (request_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (req.command == CMD_MAP) begin
          state_next = reject ? ST_MAP_FAIL : ST_MAP_WALK;
        end else begin
          state_next = len_ok ? ST_UNMAP_WALK : ST_UNMAP_DONE;
        end
      end
      ST_MAP_WALK: begin
        if (i_valid) begin
          if (fit) state_next = ST_MAP_PLACE;
        end else begin
          state_next = tail_fit ? ST_MAP_PLACE : ST_MAP_FAIL;
        end
      end
      ST_MAP_PLACE, ST_MAP_FAIL, ST_UNMAP_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_UNMAP_WALK: begin
        if (!walk) state_next = ST_UNMAP_DONE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    emit = 1'b0;
    rsp_d = '0;
    i_step = 2'd0;
    set_err = 1'b0;
    case (state)
      ST_MAP_PLACE: begin
        if (out_free) begin
          emit = 1'b1;
          op = OP_INSERT;
          rsp_d.kind = KIND_MAP;
          rsp_d.status = STATUS_OK;
          rsp_d.range_start = hi - len_r[31:0];
          rsp_d.range_end = hi - 32'd1;
          rsp_d.last = 1'b1;
        end
      end
      ST_MAP_FAIL: begin
        if (out_free) begin
          emit = 1'b1;
          rsp_d.kind = KIND_MAP;
          rsp_d.status = STATUS_ERR;
          rsp_d.last = 1'b1;
        end
      end
      ST_UNMAP_WALK: begin
        if (walk) begin
          if (!overlap) begin
            i_step = 2'd1;
          end else if (out_free) begin
            emit = 1'b1;
            rsp_d.kind = KIND_FREED;
            rsp_d.status = STATUS_OK;
            rsp_d.range_start = front ? cur.first_byte : req.address;
            rsp_d.range_end = back ? cur.last_byte : 32'(e_r - 33'd1);
            if (front && back) begin
              op = OP_DELETE;
            end else if (front) begin
              op = OP_TRIM_FRONT;
              i_step = 2'd1;
            end else if (back) begin
              op = OP_TRIM_BACK;
              i_step = 2'd1;
            end else if (full) begin
              // split impossible, range stays mapped
              rsp_d.status = STATUS_ERR;
              set_err = 1'b1;
              i_step = 2'd1;
            end else begin
              op = OP_SPLIT;
              i_step = 2'd2;
            end
          end
        end
      end
      ST_UNMAP_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          rsp_d.kind = KIND_DONE;
          rsp_d.status = err;
          rsp_d.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      response_valid <= 1'b0;
      process_top <= '0;
      err <= 1'b0;
      i <= '0;
      n <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) process_top <= cfg_data;

      if (emit) begin
        response_valid <= 1'b1;
        response <= rsp_d;
      end else if (response_ready) begin
        response_valid <= 1'b0;
      end

      if (request_valid && request_ready) begin
        req <= request;
        len_ok <= len_pos;
        len_r <= len_pos ? len_round : 33'd0;
        e_r <= {1'b0, request.address} + (len_pos ? len_round : 33'd0);
      end

      case (state)
        ST_DECODE: begin
          i <= '0;
          n <= '0;
          err <= 1'b0;
          hi <= TOP_ADDRESS;
        end
        ST_MAP_WALK: begin
          if (i_valid && fit) begin
            pos <= i;
          end else if (i_valid) begin
            hi <= cur.first_byte;
            i <= i + CW'(1);
          end else begin
            pos <= count;
          end
        end
        ST_UNMAP_WALK: begin
          i <= i + CW'(i_step);
          if (emit) n <= n + CW'(1);
          if (set_err) err <= 1'b1;
        end
        default: ;
      endcase

      if (op == OP_INSERT || op == OP_SPLIT) count <= count + CW'(1);
      else if (op == OP_DELETE) count <= count - CW'(1);
    end
  end

  // region table: shifts keep it in descending address order
  always_ff @(posedge clk) begin
    case (op)
      OP_INSERT, OP_SPLIT: begin
        for (int j = 1; j < MAX_REGIONS; j++) begin
          if (CW'(j) > ((op == OP_INSERT) ? pos : i)) tbl[j] <= tbl[j-1];
        end
        if (op == OP_INSERT) begin
          tbl[pos[IW-1:0]] <= '{first_byte: hi - len_r[31:0],
                                last_byte:  hi - 32'd1,
                                protection: req.protection,
                                flags:      req.map_flags,
                                offset:     {1'b0, req.file_offset},
                                file:       req.file_index[FILE_BITS-1:0]};
        end else begin
          tbl[idx_up] <= '{first_byte: e_r[31:0],
                          last_byte:  cur.last_byte,
                          protection: cur.protection,
                          flags:      cur.flags,
                          offset:     cur.offset + (e_r[31:0] - cur.first_byte),
                          file:       cur.file};
          tbl[idx].last_byte <= req.address - 32'd1;
        end
      end
      OP_DELETE: begin
        for (int j = 0; j < MAX_REGIONS - 1; j++) begin
          if (CW'(j) >= i) tbl[j] <= tbl[j+1];
        end
      end
      OP_TRIM_FRONT: begin
        tbl[idx].first_byte <= e_r[31:0];
        tbl[idx].offset <= cur.offset + (e_r[31:0] - cur.first_byte);
      end
      OP_TRIM_BACK: begin
        tbl[idx].last_byte <= req.address - 32'd1;
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= MAX_CNT)
    else $error("region count above table size");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst) emit |-> out_free)
    else $error("result overwrote a beat not yet taken");

  a_idle_no_op: assert property (@(posedge clk) disable iff (rst)
    (request_valid && request_ready) |-> (op == OP_NONE))
    else $error("table changed while accepting a request");

  a_reset_count: assert property (@(posedge clk) $past(rst) |-> (count == '0))
    else $error("region count not cleared by reset");

endmodule

### tb/sv/tb.sv
// testbench: region allocator checked against a behavioral table model
module tb;
  import mra_pkg::*;

  localparam int NREG = 16;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic request_valid = 1'b0;
  logic request_ready;
  request_t request = '0;
  logic response_valid;
  logic response_ready = 1'b0;
  response_t response;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  mmap_region_allocator dut (
    .clk(clk), .rst(rst),
    .request_valid(request_valid), .request_ready(request_ready), .request(request),
    .response_valid(response_valid), .response_ready(response_ready), .response(response),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow of the region table
  logic [31:0] tbl_start [NREG+1];
  logic [31:0] tbl_end [NREG+1];
  logic [31:0] tbl_off [NREG+1];
  int tbl_count = 0;
  logic [31:0] heap_top = '0;

  request_t pending_reqs[$];
  response_t due_resps[$];
  int errors = 0;
  int send_idle = 0;  // percent
  int recv_idle = 0;
  bit recv_hold = 1'b0;
  int quiet = 0;
  bit in_taken = 1'b0;

  task automatic report(input string what);
    errors++;
    $display("error: %s", what);
  endtask

  function automatic response_t beat(logic [1:0] k, logic s, logic [31:0] a,
                                     logic [31:0] b, logic l);
    response_t r;
    r.kind = k; r.status = s; r.range_start = a; r.range_end = b; r.last = l;
    return r;
  endfunction

  function automatic longint round_pages(longint len);
    if (len > 0) return ((len + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    return -(((-len) / PAGE_BYTES) * PAGE_BYTES);
  endfunction

  function automatic void open_at(int i);
    for (int j = tbl_count; j > i; j--) begin
      tbl_start[j] = tbl_start[j-1]; tbl_end[j] = tbl_end[j-1]; tbl_off[j] = tbl_off[j-1];
    end
    tbl_count++;
  endfunction

  function automatic void close_at(int i);
    for (int j = i; j + 1 < tbl_count; j++) begin
      tbl_start[j] = tbl_start[j+1]; tbl_end[j] = tbl_end[j+1]; tbl_off[j] = tbl_off[j+1];
    end
    tbl_count--;
  endfunction

  function automatic void predict_map(request_t q);
    longint len, hi;
    int pos;
    bit found;
    len = round_pages(longint'(q.length));
    hi = longint'(TOP_ADDRESS);
    found = 0; pos = 0;
    if (q.file_index < 0 || q.file_index >= FILE_SLOTS || !q.file_open ||
        q.address >= TOP_ADDRESS || len <= 0 || len > 64'd2147483647 || tbl_count >= NREG) begin
      due_resps.push_back(beat(KIND_MAP, STATUS_ERR, '0, '0, 1'b1));
      return;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (hi - longint'(tbl_end[i]) - 1 >= len) begin
        pos = i; found = 1; break;
      end
      hi = longint'(tbl_start[i]);
    end
    if (!found && hi - longint'(heap_top) >= len) begin
      pos = tbl_count; found = 1;
    end
    if (!found) begin
      due_resps.push_back(beat(KIND_MAP, STATUS_ERR, '0, '0, 1'b1));
      return;
    end
    open_at(pos);
    tbl_start[pos] = 32'(hi - len);
    tbl_end[pos] = 32'(hi - 1);
    tbl_off[pos] = {1'b0, q.file_offset};
    due_resps.push_back(beat(KIND_MAP, STATUS_OK, 32'(hi - len), 32'(hi - 1), 1'b1));
  endfunction

  function automatic void predict_unmap(request_t q);
    longint a, e, s, t, len;
    int i, n;
    logic err;
    a = longint'(q.address);
    len = round_pages(longint'(q.length));
    i = 0; n = 0; err = STATUS_OK;
    if (len > 0) begin
      e = a + len;
      while (i < tbl_count && n < NREG) begin
        s = longint'(tbl_start[i]);
        t = longint'(tbl_end[i]);
        if (!(s < e && t >= a)) begin
          i++;
        end else if (a <= s && e > t) begin
          due_resps.push_back(beat(KIND_FREED, STATUS_OK, 32'(s), 32'(t), 1'b0)); n++;
          close_at(i);
        end else begin
          if (a <= s) begin
            due_resps.push_back(beat(KIND_FREED, STATUS_OK, 32'(s), 32'(e - 1), 1'b0));
            tbl_off[i] = tbl_off[i] + 32'(e - s);
            tbl_start[i] = 32'(e);
          end else if (e > t) begin
            due_resps.push_back(beat(KIND_FREED, STATUS_OK, 32'(a), 32'(t), 1'b0));
            tbl_end[i] = 32'(a - 1);
          end else if (tbl_count >= NREG) begin
            due_resps.push_back(beat(KIND_FREED, STATUS_ERR, 32'(a), 32'(e - 1), 1'b0));
            err = STATUS_ERR;
          end else begin
            due_resps.push_back(beat(KIND_FREED, STATUS_OK, 32'(a), 32'(e - 1), 1'b0));
            open_at(i + 1);
            tbl_start[i+1] = 32'(e);
            tbl_end[i+1] = 32'(t);
            tbl_off[i+1] = tbl_off[i] + 32'(e - s);
            tbl_end[i] = 32'(a - 1);
            i++;
          end
          n++;
          i++;
        end
      end
    end
    due_resps.push_back(beat(KIND_DONE, err, '0, '0, 1'b1));
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      request_valid <= 1'b0;
    end else if (!request_valid || in_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
        request <= pending_reqs.pop_front();
        request_valid <= 1'b1;
      end else begin
        request_valid <= 1'b0;
      end
    end
    response_ready <= !rst && !recv_hold && ($urandom_range(99) >= recv_idle);
  end

  // marks a request beat taken at this edge
  always @(posedge clk) begin
    in_taken <= !rst && request_valid && request_ready;
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((request_valid && request_ready) || (response_valid && response_ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (request_valid && request_ready) begin
        if (request.command == CMD_MAP) predict_map(request);
        else predict_unmap(request);
      end
      if (cfg_valid && cfg_ready) heap_top = cfg_data;
      if (response_valid && response_ready) begin
        if (due_resps.size() == 0) begin
          report($sformatf("unexpected beat %p", response));
        end else begin
          response_t x;
          x = due_resps.pop_front();
          if (response.kind !== x.kind) report($sformatf("kind %0d want %0d", response.kind, x.kind));
          if (response.status !== x.status) report($sformatf("status %0d want %0d",
                                                              response.status, x.status));
          if (response.range_start !== x.range_start)
            report($sformatf("start %h want %h", response.range_start, x.range_start));
          if (response.range_end !== x.range_end)
            report($sformatf("end %h want %h", response.range_end, x.range_end));
          if (response.last !== x.last) report($sformatf("last %0d want %0d", response.last, x.last));
        end
      end
      if (quiet >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic request_t mk(logic c, logic [31:0] a, logic [31:0] l);
    request_t q;
    q.command = c; q.address = a; q.length = l;
    q.protection = 8'($urandom); q.map_flags = 8'($urandom);
    q.file_offset = 31'($urandom); q.file_index = 8'($urandom_range(15)); q.file_open = 1'b1;
    return q;
  endfunction

  function automatic request_t rnd_req();
    request_t q;
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      q = mk(CMD_MAP, $urandom_range(32'h7fff_ffff), $urandom_range(1, 5 * PAGE_BYTES));
      if ($urandom_range(9) == 0) q.file_index = 8'($urandom);
      if ($urandom_range(19) == 0) q.file_open = 1'b0;
      if ($urandom_range(19) == 0) q.address = $urandom;
      if ($urandom_range(19) == 0) q.length = $urandom;
    end else if (r < 90) begin
      // aim into the upper part where regions live
      q = mk(CMD_UNMAP, 32'h8000_0000 - $urandom_range(1, 40) * PAGE_BYTES
             + ($urandom_range(1) ? $urandom_range(4095) : 0), $urandom_range(1, 8 * PAGE_BYTES));
    end else begin
      q = mk(CMD_UNMAP, $urandom, $urandom);
    end
    q.file_offset = $urandom_range(1) ? 31'($urandom) : 31'h7fff_ffff;
    return q;
  endfunction

  task automatic settle();
    while (pending_reqs.size() > 0 || request_valid || due_resps.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_top(input logic [31:0] v);
    @(negedge clk);
    cfg_data <= v; cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int si, input int ri);
    send_idle = si; recv_idle = ri;
    repeat (n) pending_reqs.push_back(rnd_req());
    settle();
  endtask

  initial begin
    request_t q;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_top(32'h0);
    // directed: extremes and rejects
    pending_reqs.push_back(mk(CMD_MAP, 32'h0, 32'h1));
    pending_reqs.push_back(mk(CMD_MAP, 32'h7fff_ffff, 32'h0000_2000));
    pending_reqs.push_back(mk(CMD_MAP, 32'h8000_0000, 32'h1000));
    pending_reqs.push_back(mk(CMD_MAP, 32'hffff_ffff, 32'h1000));
    q = mk(CMD_MAP, 32'h0, 32'h1000); q.file_index = -8'sd128; pending_reqs.push_back(q);
    q = mk(CMD_MAP, 32'h0, 32'h1000); q.file_index = 8'sd16; pending_reqs.push_back(q);
    q = mk(CMD_MAP, 32'h0, 32'h1000); q.file_index = 8'sd127; pending_reqs.push_back(q);
    q = mk(CMD_MAP, 32'h0, 32'h1000); q.file_open = 1'b0; pending_reqs.push_back(q);
    pending_reqs.push_back(mk(CMD_MAP, 32'h0, 32'h0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h0, 32'h8000_0000));
    pending_reqs.push_back(mk(CMD_MAP, 32'h0, 32'h7fff_ffff));
    pending_reqs.push_back(mk(CMD_MAP, 32'h0, 32'h1000));
    // unmap across the first two regions, trimming the front of one and the back of the other
    pending_reqs.push_back(mk(CMD_UNMAP, 32'h7fff_e123, 32'h10));
    pending_reqs.push_back(mk(CMD_UNMAP, 32'h0, 32'hffff_f000));
    pending_reqs.push_back(mk(CMD_UNMAP, 32'hffff_f000, 32'h7fff_ffff));
    pending_reqs.push_back(mk(CMD_UNMAP, 32'h0, 32'h7fff_ffff));
    q = mk(CMD_UNMAP, 32'h0, 32'h1000); q.command = CMD_UNMAP; q.file_open = 1'b0;
    pending_reqs.push_back(q);
    // fill the table, then split with it full
    repeat (17) pending_reqs.push_back(mk(CMD_MAP, 32'h0, 32'h3000));
    pending_reqs.push_back(mk(CMD_UNMAP, 32'h7fff_e000, 32'h1000));
    settle();
    run_phase(30, 0, 0);
    write_top(32'h7ff0_0000);
    run_phase(30, 67, 0);
    // long receiver hold with the sender still offering
    recv_hold = 1'b1;
    send_idle = 0;
    repeat (10) pending_reqs.push_back(rnd_req());
    repeat (400) @(posedge clk);
    recv_hold = 1'b0;
    settle();
    write_top(32'h8000_0000);
    run_phase(15, 0, 67);
    write_top(32'h7fff_0000);
    run_phase(30, 0, 67);
    write_top(32'h7ffc_0000);
    run_phase(10, 18, 18);
    repeat (100) @(posedge clk);
    if (errors == 0 && due_resps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
